// ===== rtl/core/osu_pkg.sv =====
// osu_pkg: shared constants, codes, types and helpers for the ordered set union block
// no dependencies; imported by the cell, the cell row and the top level

package osu_pkg;

	// sizing of the stored first list and of the union
	localparam int LIST_DEPTH = 64;
	localparam int UNION_CAP  = 2 * LIST_DEPTH;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int POS_W      = $clog2(UNION_CAP + 1);

	// fixed field widths
	localparam int ID_W      = 32;
	localparam int CMD_W     = 2;
	localparam int KIND_W    = 2;
	localparam int POS_OUT_W = 7;
	localparam int SIZE_W    = 8;
	localparam int RANK_W    = 8;
	localparam int SRANK_W   = 7;

	// rank meaning "not a member"
	localparam logic [RANK_W-1:0]  RANK_NONE  = '1;
	localparam logic [SRANK_W-1:0] SRANK_NONE = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_START  = 2'd0,
		CMD_FIRST  = 2'd1,
		CMD_SECOND = 2'd2,
		CMD_FINISH = 2'd3
	} osu_cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_MEMBER   = 2'd0,
		KIND_SUMMARY  = 2'd1,
		KIND_OVERFLOW = 2'd2
	} osu_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} osu_state_t;

	// search token walking the cell row
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
		logic            hit;
	} osu_probe_t;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [POS_OUT_W-1:0] position;
		logic [ID_W-1:0]      out_member;
		logic [SIZE_W-1:0]    union_size;
		logic [RANK_W-1:0]    self_rank;
	} osu_result_t;

	// union position masked to the output position field
	function automatic logic [POS_OUT_W-1:0] pos_to_field(input logic [POS_W-1:0] p);
		logic [POS_W+POS_OUT_W-1:0] w;
		w = {{POS_OUT_W{1'b0}}, p};
		return w[POS_OUT_W-1:0];
	endfunction

	// union position masked to an eight bit field
	function automatic logic [SIZE_W-1:0] pos_to_byte(input logic [POS_W-1:0] p);
		logic [POS_W+SIZE_W-1:0] w;
		w = {{SIZE_W{1'b0}}, p};
		return w[SIZE_W-1:0];
	endfunction

endpackage

// ===== rtl/core/osu_if.sv =====
// osu_cmd_if and osu_res_if: valid/ready channels for command and result transfers
// no dependencies; widths follow the fixed field widths of the block

interface osu_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] member_id;
	logic [6:0]  first_self_rank;
	logic        second_has_self;

	modport source (output valid, command, member_id, first_self_rank, second_has_self,
		input ready);
	modport sink (input valid, command, member_id, first_self_rank, second_has_self,
		output ready);
endinterface

interface osu_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [6:0]  position;
	logic [31:0] out_member;
	logic [7:0]  union_size;
	logic [7:0]  self_rank;

	modport source (output valid, kind, position, out_member, union_size, self_rank,
		input ready);
	modport sink (input valid, kind, position, out_member, union_size, self_rank,
		output ready);
endinterface

// ===== rtl/core/osu_cell.sv =====
// osu_cell: one stored first-list entry and one stage of the search token path
// depends on osu_pkg

module osu_cell import osu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [ID_W-1:0] wr_id,
	input  logic            active,
	input  osu_probe_t      probe_in,
	output osu_probe_t      probe_out
);

	logic [ID_W-1:0] entry_q;
	osu_probe_t      probe_q;

	// entry storage, written once per first-list member
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_id;
		end
	end

	// token stage: compare against the entry if it lies below the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q.valid <= probe_in.valid;
			probe_q.id    <= probe_in.id;
			probe_q.hit   <= probe_in.hit | (active & (entry_q == probe_in.id));
		end
	end

	assign probe_out = probe_q;

endmodule

// ===== rtl/core/osu_chain.sv =====
// osu_chain: row of LIST_DEPTH cells holding the first list, token moves one cell a cycle
// depends on osu_pkg and osu_cell

module osu_chain import osu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [ID_W-1:0]  wr_id,
	input  logic [CNT_W-1:0] count,
	input  osu_probe_t       probe_in,
	output osu_probe_t       probe_out
);

	osu_probe_t link [LIST_DEPTH+1];

	assign link[0] = probe_in;

	// each cell knows its own index: write select and fill check are local
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		osu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_en && (count == CNT_W'(i))),
			.wr_id     (wr_id),
			.active    (count > CNT_W'(i)),
			.probe_in  (link[i]),
			.probe_out (link[i+1])
		);
	end

	assign probe_out = link[LIST_DEPTH];

endmodule

// ===== rtl/core/ordered_set_union.sv =====
// Ordered set union. Commands arrive one at a time on cmd_ch and are taken only while the
// block is idle. A start command gives no result. A first-list member or a finish command
// is taken and its result is registered as pending; in the emit state it is loaded into
// the output register once that register is empty or being taken. A second-list member
// is searched by a token that walks the row of LIST_DEPTH cells one cell per cycle. When
// the member is found in the first list the block returns to idle and gives no result.
// When it is absent its result is registered as pending and loaded in the same way. A
// finished result may wait in the output register while the next command is taken. The
// user must write own_id through cfg_wr_en / cfg_wr_data only while the block is idle;
// the block itself does not enforce it.
// Depends on osu_pkg, osu_if and osu_chain.

module ordered_set_union import osu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [ID_W-1:0] cfg_wr_data,
	osu_cmd_if.sink         cmd_ch,
	osu_res_if.source       res_ch
);

	osu_state_t         state_q, state_d;
	logic [ID_W-1:0]    own_id_q;
	logic [CNT_W-1:0]   count_q;
	logic [POS_W-1:0]   npos_q;
	logic [RANK_W-1:0]  found_q;
	logic [SRANK_W-1:0] srank_q;
	logic               sflag_q;
	osu_result_t        pend_q, pend_d;
	osu_result_t        res_q;
	logic               res_valid_q;

	logic       accept;
	osu_cmd_t   cmd;
	logic       cmd_ready;
	logic       emit_load;
	logic       search_miss;
	logic       first_full;
	logic       union_full;
	osu_probe_t probe_launch;
	osu_probe_t probe_tail;

	assign cmd        = osu_cmd_t'(cmd_ch.command);
	assign accept     = cmd_ch.valid && cmd_ready;
	assign first_full = (count_q == CNT_W'(LIST_DEPTH));
	assign union_full = (npos_q >= POS_W'(UNION_CAP));
	assign search_miss = (state_q == ST_SEARCH) && probe_tail.valid && !probe_tail.hit;

	// cell row holding the first list
	osu_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept && (cmd == CMD_FIRST) && !first_full),
		.wr_id     (cmd_ch.member_id),
		.count     (count_q),
		.probe_in  (probe_launch),
		.probe_out (probe_tail)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_START:  state_d = ST_IDLE;
						CMD_SECOND: state_d = ST_SEARCH;
						default:    state_d = ST_EMIT;
					endcase
				end
			end
			ST_SEARCH: begin
				if (probe_tail.valid) begin
					state_d = probe_tail.hit ? ST_IDLE : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!res_valid_q || res_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_ready          = 1'b0;
		emit_load          = 1'b0;
		probe_launch       = '0;
		probe_launch.id    = cmd_ch.member_id;
		case (state_q)
			ST_IDLE: begin
				cmd_ready          = 1'b1;
				probe_launch.valid = cmd_ch.valid && (cmd == CMD_SECOND);
			end
			ST_EMIT: begin
				emit_load = !res_valid_q || res_ch.ready;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// pending result built from the command or the search outcome
	always_comb begin
		pend_d = pend_q;
		if (accept && (cmd == CMD_FIRST)) begin
			pend_d = '0;
			if (first_full) begin
				pend_d.kind = KIND_OVERFLOW;
			end else begin
				pend_d.kind       = KIND_MEMBER;
				pend_d.position   = pos_to_field(npos_q);
				pend_d.out_member = cmd_ch.member_id;
			end
		end else if (accept && (cmd == CMD_FINISH)) begin
			pend_d            = '0;
			pend_d.kind       = KIND_SUMMARY;
			pend_d.union_size = pos_to_byte(npos_q);
			if (srank_q != SRANK_NONE) begin
				pend_d.self_rank = {srank_q[SRANK_W-1], srank_q};
			end else if (sflag_q) begin
				pend_d.self_rank = found_q;
			end else begin
				pend_d.self_rank = RANK_NONE;
			end
		end else if (search_miss) begin
			pend_d = '0;
			if (union_full) begin
				pend_d.kind = KIND_OVERFLOW;
			end else begin
				pend_d.kind       = KIND_MEMBER;
				pend_d.position   = pos_to_field(npos_q);
				pend_d.out_member = probe_tail.id;
			end
		end
	end

	// pending and output payload registers
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (emit_load) begin
			res_q <= pend_q;
		end
	end

	// control and union bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			own_id_q    <= '0;
			count_q     <= '0;
			npos_q      <= '0;
			found_q     <= RANK_NONE;
			srank_q     <= SRANK_NONE;
			sflag_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				own_id_q <= cfg_wr_data;
			end
			if (accept) begin
				case (cmd)
					CMD_START: begin
						count_q <= '0;
						npos_q  <= '0;
						found_q <= RANK_NONE;
						srank_q <= cmd_ch.first_self_rank;
						sflag_q <= cmd_ch.second_has_self;
					end
					CMD_FIRST: begin
						if (!first_full) begin
							count_q <= count_q + CNT_W'(1);
							npos_q  <= npos_q + POS_W'(1);
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
			if (search_miss && !union_full) begin
				npos_q <= npos_q + POS_W'(1);
				if (probe_tail.id == own_id_q) begin
					found_q <= pos_to_byte(npos_q);
				end
			end
			// output register: a taken result frees it, a load fills it
			if (emit_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_ch.ready      = cmd_ready;
	assign res_ch.valid      = res_valid_q;
	assign res_ch.kind       = res_q.kind;
	assign res_ch.position   = res_q.position;
	assign res_ch.out_member = res_q.out_member;
	assign res_ch.union_size = res_q.union_size;
	assign res_ch.self_rank  = res_q.self_rank;

endmodule

// ===== dv/ordered_set_union_test.sv =====
// ordered_set_union_test: self-checking bench for the ordered set union block
// drives command transfers, predicts each result and compares every result transfer
// depends on osu_pkg, osu_cmd_if / osu_res_if and ordered_set_union

module ordered_set_union_test import osu_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS         = 1900;
	localparam int PHASES        = 6;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [ID_W-1:0]    member_id;
		logic [SRANK_W-1:0] first_self_rank;
		logic               second_has_self;
	} cmd_item_t;

	typedef struct packed {
		cmd_item_t   item;
		logic        typed;
		logic        typed_has;
		osu_result_t typed_res;
	} dir_row_t;

	typedef enum int {
		SHAPE_PLAIN,
		SHAPE_BROKEN,
		SHAPE_NOISE,
		SHAPE_FIRST_OVF,
		SHAPE_UNION_OVF
	} seq_shape_t;

	// directed rows, with own_id still at its reset value of zero
	localparam dir_row_t DIRECTED [25] = '{
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b1, 1'b1,
			'{KIND_SUMMARY, 7'd0, 32'h0000_0000, 8'd0, 8'hFF}},
		'{'{CMD_FIRST,  32'hFFFF_FFFF, 7'h7F, 1'b1}, 1'b1, 1'b1,
			'{KIND_MEMBER, 7'd0, 32'hFFFF_FFFF, 8'd0, 8'h00}},
		'{'{CMD_SECOND, 32'hFFFF_FFFF, 7'h00, 1'b0}, 1'b1, 1'b0, '0},
		'{'{CMD_SECOND, 32'h0000_0000, 7'h00, 1'b0}, 1'b1, 1'b1,
			'{KIND_MEMBER, 7'd1, 32'h0000_0000, 8'd0, 8'h00}},
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b1, 1'b1,
			'{KIND_SUMMARY, 7'd0, 32'h0000_0000, 8'd2, 8'hFF}},
		'{'{CMD_START,  32'h0000_0000, 7'h7F, 1'b1}, 1'b1, 1'b0, '0},
		'{'{CMD_FIRST,  32'h1234_5678, 7'h00, 1'b0}, 1'b1, 1'b1,
			'{KIND_MEMBER, 7'd0, 32'h1234_5678, 8'd0, 8'h00}},
		'{'{CMD_SECOND, 32'h0000_0000, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_SECOND, 32'h0000_0000, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_SECOND, 32'hAAAA_AAAA, 7'h55, 1'b1}, 1'b0, 1'b0, '0},
		'{'{CMD_FINISH, 32'h5555_5555, 7'h2A, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_START,  32'h0000_0000, 7'h3F, 1'b0}, 1'b1, 1'b0, '0},
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b1, 1'b1,
			'{KIND_SUMMARY, 7'd0, 32'h0000_0000, 8'd0, 8'd63}},
		'{'{CMD_START,  32'h0000_0000, 7'h40, 1'b1}, 1'b1, 1'b0, '0},
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b1, 1'b1,
			'{KIND_SUMMARY, 7'd0, 32'h0000_0000, 8'd0, 8'hC0}},
		'{'{CMD_START,  32'h0000_0000, 7'h7E, 1'b0}, 1'b1, 1'b0, '0},
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b1, 1'b1,
			'{KIND_SUMMARY, 7'd0, 32'h0000_0000, 8'd0, 8'hFE}},
		'{'{CMD_START,  32'h0000_0000, 7'h00, 1'b1}, 1'b0, 1'b0, '0},
		'{'{CMD_SECOND, 32'h5555_5555, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_START,  32'h0000_0000, 7'h7F, 1'b1}, 1'b0, 1'b0, '0},
		'{'{CMD_SECOND, 32'h0000_0005, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_FINISH, 32'h0000_0000, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
		'{'{CMD_FIRST,  32'h0000_0000, 7'h00, 1'b0}, 1'b0, 1'b0, '0}
	};

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [ID_W-1:0] cfg_wr_data;

	osu_cmd_if cmd_ch();
	osu_res_if res_ch();

	ordered_set_union dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_ch      (cmd_ch),
		.res_ch      (res_ch)
	);

	// predicted block state
	logic [ID_W-1:0] own_id_q;
	logic [ID_W-1:0] first_ids [LIST_DEPTH];
	int              first_cnt;
	int              union_pos;
	int              own_pos;
	int              open_rank;
	logic            second_self;

	osu_result_t results_due [$];
	int          items_sent;
	int          mismatches;
	bit          idle_on;
	bit          calm;
	bit          hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one command through the union; returns 1 when it gives a result
	function automatic bit union_step(input cmd_item_t it, output osu_result_t r);
		int resolved;
		r = '0;
		case (it.command)
			CMD_START: begin
				first_cnt   = 0;
				union_pos   = 0;
				own_pos     = -1;
				open_rank   = int'($signed(it.first_self_rank));
				second_self = it.second_has_self;
				return 1'b0;
			end
			CMD_FIRST: begin
				if (first_cnt >= LIST_DEPTH) begin
					r.kind = KIND_OVERFLOW;
					return 1'b1;
				end
				first_ids[first_cnt] = it.member_id;
				first_cnt++;
				r.kind       = KIND_MEMBER;
				r.position   = union_pos[POS_OUT_W-1:0];
				r.out_member = it.member_id;
				union_pos++;
				return 1'b1;
			end
			CMD_SECOND: begin
				for (int j = 0; j < first_cnt; j++)
					if (first_ids[j] == it.member_id)
						return 1'b0;
				if (union_pos >= UNION_CAP) begin
					r.kind = KIND_OVERFLOW;
					return 1'b1;
				end
				if (it.member_id == own_id_q)
					own_pos = union_pos;
				r.kind       = KIND_MEMBER;
				r.position   = union_pos[POS_OUT_W-1:0];
				r.out_member = it.member_id;
				union_pos++;
				return 1'b1;
			end
			default: begin
				if (open_rank != -1)
					resolved = open_rank;
				else if (second_self)
					resolved = own_pos;
				else
					resolved = -1;
				r.kind       = KIND_SUMMARY;
				r.union_size = union_pos[SIZE_W-1:0];
				r.self_rank  = resolved[RANK_W-1:0];
				return 1'b1;
			end
		endcase
	endfunction

	function automatic cmd_item_t make_item(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
			input logic [SRANK_W-1:0] rank, input logic has);
		cmd_item_t it;
		it.command         = c;
		it.member_id       = id;
		it.first_self_rank = rank;
		it.second_has_self = has;
		return it;
	endfunction

	// offer one command, wait for its transfer, then queue what it should give
	task automatic send_item(input cmd_item_t it, input bit typed, input bit typed_has,
			input osu_result_t typed_res);
		osu_result_t pred;
		bit          has;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		cmd_ch.valid           <= 1'b1;
		cmd_ch.command         <= it.command;
		cmd_ch.member_id       <= it.member_id;
		cmd_ch.first_self_rank <= it.first_self_rank;
		cmd_ch.second_has_self <= it.second_has_self;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
		has = union_step(it, pred);
		if (typed) begin
			if (typed_has)
				results_due.push_back(typed_res);
		end else if (has) begin
			results_due.push_back(pred);
		end
	endtask

	// stop offering, let every result out and the search finish
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_own_id(input logic [ID_W-1:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		own_id_q = v;
	endtask

	// one union: start, first list, second list, finish, or noise / broken variants
	task automatic run_sequence(input seq_shape_t shape);
		logic [ID_W-1:0] firsts [$];
		logic [ID_W-1:0] seconds [$];
		logic [ID_W-1:0] id;
		logic [SRANK_W-1:0] rank;
		int n_first;
		int n_second;
		int r;
		bit with_start;
		bit with_finish;
		with_start  = 1'b1;
		with_finish = 1'b1;
		n_first     = $urandom_range(0, 8);
		n_second    = $urandom_range(0, 8);
		case (shape)
			SHAPE_NOISE: begin
				repeat ($urandom_range(1, 4)) begin
					id = ($urandom_range(0, 3) == 0) ? own_id_q : $urandom;
					send_item(make_item(CMD_W'($urandom_range(0, 3)), id,
						SRANK_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1))),
						1'b0, 1'b0, '0);
				end
				return;
			end
			SHAPE_BROKEN: begin
				r = $urandom_range(0, 2);
				with_start  = (r == 1);
				with_finish = (r == 0);
			end
			SHAPE_FIRST_OVF: n_first = LIST_DEPTH + $urandom_range(1, 4);
			SHAPE_UNION_OVF: begin
				n_first  = LIST_DEPTH;
				n_second = LIST_DEPTH + $urandom_range(1, 4);
			end
			default: ;
		endcase

		// start: mostly absent or an in-range rank, sometimes any raw value
		if (with_start) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				rank = SRANK_NONE;
			else if (r < 9)
				rank = SRANK_W'($urandom_range(0, 63));
			else
				rank = SRANK_W'($urandom_range(0, 127));
			send_item(make_item(CMD_START, $urandom, rank, 1'($urandom_range(0, 1))),
				1'b0, 1'b0, '0);
		end

		// first list, with the own id and repeats now and then
		repeat (n_first) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				id = own_id_q;
			else if (r < 3 && firsts.size() != 0)
				id = firsts[$urandom_range(0, firsts.size() - 1)];
			else
				id = $urandom;
			firsts.push_back(id);
			send_item(make_item(CMD_FIRST, id, SRANK_W'($urandom_range(0, 127)),
				1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
		end

		// second list, mixing members of the first list, the own id, repeats and fresh ones
		repeat (n_second) begin
			r = $urandom_range(0, 19);
			if (shape == SHAPE_UNION_OVF)
				id = $urandom;
			else if (r < 7 && firsts.size() != 0)
				id = firsts[$urandom_range(0, firsts.size() - 1)];
			else if (r < 10)
				id = own_id_q;
			else if (r < 12 && seconds.size() != 0)
				id = seconds[$urandom_range(0, seconds.size() - 1)];
			else
				id = $urandom;
			seconds.push_back(id);
			send_item(make_item(CMD_SECOND, id, SRANK_W'($urandom_range(0, 127)),
				1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
		end

		if (with_finish)
			send_item(make_item(CMD_FINISH, $urandom, SRANK_W'($urandom_range(0, 127)),
				1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
	endtask

	// result side: random ready bursts plus one long hold-off on request
	initial begin : result_sink
		int gap;
		int hold;
		gap  = 0;
		hold = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold     = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(0, 8);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		osu_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				$error("result transfer with nothing expected: kind %0d", res_ch.kind);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (res_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
					mismatches++;
				end
				if (res_ch.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, res_ch.position);
					mismatches++;
				end
				if (res_ch.out_member !== want.out_member) begin
					$error("out_member: expected %h, got %h", want.out_member, res_ch.out_member);
					mismatches++;
				end
				if (res_ch.union_size !== want.union_size) begin
					$error("union_size: expected %0d, got %0d", want.union_size,
						res_ch.union_size);
					mismatches++;
				end
				if (res_ch.self_rank !== want.self_rank) begin
					$error("self_rank: expected %h, got %h", want.self_rank, res_ch.self_rank);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// reset, directed table, then random phases under several own ids
	initial begin : stimulus
		logic [ID_W-1:0] phase_id;
		int              goal;
		int              r;
		seq_shape_t      shape;
		items_sent  = 0;
		mismatches  = 0;
		idle_on     = 1'b0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		own_id_q    = '0;
		first_cnt   = 0;
		union_pos   = 0;
		own_pos     = -1;
		open_rank   = -1;
		second_self = 1'b0;
		arst_n                 <= 1'b0;
		cfg_wr_en              <= 1'b0;
		cfg_wr_data            <= '0;
		cmd_ch.valid           <= 1'b0;
		cmd_ch.command         <= CMD_START;
		cmd_ch.member_id       <= '0;
		cmd_ch.first_self_rank <= '0;
		cmd_ch.second_has_self <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].typed_has,
				DIRECTED[i].typed_res);

		for (int ph = 1; ph <= PHASES; ph++) begin
			case (ph)
				1:       phase_id = '1;
				2:       phase_id = '0;
				default: phase_id = $urandom;
			endcase
			write_own_id(phase_id);
			calm = (ph == PHASES);
			// long result hold-off while commands keep coming
			if (ph == 3)
				hold_req = 1'b1;
			goal = items_sent + ITEMS / PHASES;
			idle_on = !calm;
			if (ph == 1)
				run_sequence(SHAPE_FIRST_OVF);
			if (ph == 2)
				run_sequence(SHAPE_UNION_OVF);
			while (items_sent < goal) begin
				idle_on = !calm && ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 6)
					shape = SHAPE_NOISE;
				else if (r < 12)
					shape = SHAPE_BROKEN;
				else if (r < 13)
					shape = SHAPE_FIRST_OVF;
				else if (r < 14)
					shape = SHAPE_UNION_OVF;
				else
					shape = SHAPE_PLAIN;
				run_sequence(shape);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
